### hdl/two_pad_swipe_detector_macros.svh
// ----------------------------------------------------------------------------
// Two pad swipe detector assertion macros
// Shared shorthand for the concurrent checks in the detector's modules.
// ----------------------------------------------------------------------------
`ifndef TWO_PAD_SWIPE_DETECTOR_MACROS_SVH
`define TWO_PAD_SWIPE_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define TPSD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define TPSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// Two pad swipe detector package
// Widths, pad and gesture codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package tpsd_pkg;

   // Depth of the pad sequence store.
   localparam int SEQ_DEPTH = 8;
   localparam int IDX_W     = $clog2(SEQ_DEPTH);
   localparam int LEN_W     = $clog2(SEQ_DEPTH + 1);

   localparam int LEVEL_W = 16;
   localparam int TIME_W  = 32;
   localparam int MS_W    = 16;
   localparam int MIN_W   = 6;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] PAD_NONE = 2'd0;
   localparam logic [1:0] PAD_A    = 2'd1;
   localparam logic [1:0] PAD_B    = 2'd2;

   localparam logic [1:0] GEST_NONE = 2'd0;
   localparam logic [1:0] GEST_DOWN = 2'd1;
   localparam logic [1:0] GEST_UP   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TOUCH_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GESTURE_MAX_MS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_MS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_TRANSITIONS = 2'd3;

   typedef struct packed {
      logic capture;
      logic evaluate;
      logic scan;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_scan;
      logic scan_last;
   } dp_status_type;

endpackage

### hdl/tpsd_datapath.sv
// ----------------------------------------------------------------------------
// Two pad swipe detector datapath
// Settings, tick capture, gesture recording state, sequence store, judge, result.
// ----------------------------------------------------------------------------
module tpsd_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tpsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpsd_pkg::CSR_W-1:0]     csr_wdata,
   input  logic [tpsd_pkg::LEVEL_W-1:0]   req_raw_a_level,
   input  logic [tpsd_pkg::LEVEL_W-1:0]   req_raw_b_level,
   input  logic [tpsd_pkg::TIME_W-1:0]    req_now_ms,
   input  tpsd_pkg::ctrl_cmd_type         cmd,
   output tpsd_pkg::dp_status_type        status,
   output logic [1:0]                     rsp_gesture_code,
   output logic                           rsp_pad_a_touched,
   output logic                           rsp_pad_b_touched
);
   import tpsd_pkg::*;

`include "two_pad_swipe_detector_macros.svh"

   logic [LEVEL_W-1:0] threshold_ff;
   logic [MS_W-1:0]    max_ms_ff;
   logic [MS_W-1:0]    debounce_ff;
   logic [MIN_W-1:0]   min_trans_ff;

   logic [LEVEL_W-1:0] raw_a_ff;
   logic [LEVEL_W-1:0] raw_b_ff;
   logic [TIME_W-1:0]  now_ff;

   logic [1:0]         seq_ff [SEQ_DEPTH];
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [1:0]         held_ff, held_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0]  last_ff, last_in;

   logic               touch_a_ff, touch_b_ff;
   logic               judged_ff;
   logic [LEN_W-1:0]   scan_len_ff;
   logic [IDX_W-1:0]   scan_idx_ff;
   logic [1:0]         first_ff;
   logic [1:0]         prev_ff;
   logic               mismatch_ff;

   logic [1:0]         gesture_code_ff;
   logic               pad_a_ff, pad_b_ff;

   logic               touch_a, touch_b;
   logic [1:0]         dominant;
   logic [TIME_W-1:0]  since_start, since_change;
   logic               abort_rec, append, release_rec, judge;
   logic               seq_wr;
   logic [IDX_W-1:0]   seq_wr_idx;
   logic [1:0]         scan_entry;
   logic [1:0]         code;

   // Settings register file, to be written only while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= LEVEL_W'(40);
         max_ms_ff    <= MS_W'(1500);
         debounce_ff  <= MS_W'(40);
         min_trans_ff <= MIN_W'(2);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TOUCH_THRESHOLD: threshold_ff <= csr_wdata[LEVEL_W-1:0];
            REG_GESTURE_MAX_MS:  max_ms_ff    <= csr_wdata[MS_W-1:0];
            REG_DEBOUNCE_MS:     debounce_ff  <= csr_wdata[MS_W-1:0];
            REG_MIN_TRANSITIONS: min_trans_ff <= csr_wdata[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         raw_a_ff <= req_raw_a_level;
         raw_b_ff <= req_raw_b_level;
         now_ff   <= req_now_ms;
      end
   end

   // Tick evaluation.
   always_comb begin
      touch_a = raw_a_ff <= threshold_ff;
      touch_b = raw_b_ff <= threshold_ff;
      if (touch_a && touch_b) begin
         dominant = (held_ff != PAD_NONE) ? held_ff : PAD_A;
      end else if (touch_a) begin
         dominant = PAD_A;
      end else if (touch_b) begin
         dominant = PAD_B;
      end else begin
         dominant = PAD_NONE;
      end

      since_start  = now_ff - start_ff;
      since_change = now_ff - last_ff;
      abort_rec    = (len_ff != '0) && (since_start > TIME_W'(max_ms_ff));
      append       = (len_ff != '0) && !abort_rec && (dominant != PAD_NONE) &&
                     (dominant != held_ff) && (since_change >= TIME_W'(debounce_ff)) &&
                     (len_ff < LEN_W'(SEQ_DEPTH));
      release_rec  = (len_ff != '0) && !abort_rec && !touch_a && !touch_b;
      judge        = release_rec && (MIN_W'(len_ff) >= min_trans_ff);

      len_in     = len_ff;
      held_in    = held_ff;
      start_in   = start_ff;
      last_in    = last_ff;
      seq_wr     = 1'b0;
      seq_wr_idx = IDX_W'(len_ff);
      if (len_ff == '0) begin
         if (dominant != PAD_NONE) begin
            start_in   = now_ff;
            last_in    = now_ff;
            seq_wr     = 1'b1;
            seq_wr_idx = '0;
            len_in     = LEN_W'(1);
            held_in    = dominant;
         end
      end else if (abort_rec || release_rec) begin
         len_in  = '0;
         held_in = PAD_NONE;
      end else if (append) begin
         seq_wr  = 1'b1;
         len_in  = len_ff + LEN_W'(1);
         held_in = dominant;
         last_in = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         held_ff  <= PAD_NONE;
         start_ff <= '0;
         last_ff  <= '0;
      end else if (cmd.evaluate) begin
         len_ff   <= len_in;
         held_ff  <= held_in;
         start_ff <= start_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.evaluate && seq_wr) begin
         seq_ff[seq_wr_idx] <= dominant;
      end
   end

   // Judging walks the store one entry per cycle.
   assign scan_entry = seq_ff[scan_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         judged_ff   <= 1'b0;
         mismatch_ff <= 1'b0;
         scan_idx_ff <= '0;
      end else if (cmd.evaluate) begin
         judged_ff   <= judge;
         mismatch_ff <= 1'b0;
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         if (scan_idx_ff != '0 && scan_entry == prev_ff) begin
            mismatch_ff <= 1'b1;
         end
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         touch_a_ff  <= touch_a;
         touch_b_ff  <= touch_b;
         scan_len_ff <= len_ff;
      end
      if (cmd.scan) begin
         if (scan_idx_ff == '0) begin
            first_ff <= scan_entry;
         end
         prev_ff <= scan_entry;
      end
   end

   assign status.start_scan = judge;
   assign status.scan_last  = LEN_W'(scan_idx_ff) == (scan_len_ff - LEN_W'(1));

   always_comb begin
      if (judged_ff && !mismatch_ff) begin
         code = (first_ff == PAD_A) ? GEST_DOWN : GEST_UP;
      end else begin
         code = GEST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         gesture_code_ff <= code;
         pad_a_ff        <= touch_a_ff;
         pad_b_ff        <= touch_b_ff;
      end
   end

   assign rsp_gesture_code  = gesture_code_ff;
   assign rsp_pad_a_touched = pad_a_ff;
   assign rsp_pad_b_touched = pad_b_ff;

   `TPSD_ASSERT_SAME(a_len_bound, 1'b1, len_ff <= LEN_W'(SEQ_DEPTH), "sequence length beyond store depth")
   `TPSD_ASSERT_SAME(a_held_len, 1'b1, (len_ff == '0) == (held_ff == PAD_NONE), "held pad disagrees with sequence length")
   `TPSD_ASSERT_SAME(a_scan_len, cmd.scan, scan_len_ff != '0 && judged_ff, "store walked without a judged sequence")

endmodule

### hdl/tpsd_ctrl.sv
// ----------------------------------------------------------------------------
// Two pad swipe detector controller
// Sequences capture, evaluation, the store walk and the result register.
// ----------------------------------------------------------------------------
module tpsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tpsd_pkg::dp_status_type status,
   output tpsd_pkg::ctrl_cmd_type  cmd
);
   import tpsd_pkg::*;

`include "two_pad_swipe_detector_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.evaluate = 1'b1;
            state_in     = status.start_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `TPSD_ASSERT_NEXT(a_accept_eval, req_valid && !req_stall, state_ff == ST_EVAL, "accepted word not evaluated next")
   `TPSD_ASSERT_NEXT(a_scan_done, state_ff == ST_SCAN && status.scan_last, state_ff == ST_DONE, "store walk overran")
   `TPSD_ASSERT_NEXT(a_load_valid, state_ff == ST_DONE && slot_free, rsp_valid_ff && state_ff == ST_IDLE, "result not presented")

endmodule

### hdl/two_pad_swipe_detector.sv
// ----------------------------------------------------------------------------
// Two pad swipe detector
// Turns ticks of two capacitive pad readings into swipe up and down gestures.
// ----------------------------------------------------------------------------
// Each input word carries one tick: the raw readings of pads A and B and a
// free-running millisecond timestamp, and every tick gives exactly one result
// word with the gesture code and the two touch flags. The block works on one
// tick at a time. A tick goes through capture, evaluate and result load when
// it does not end a gesture that qualifies for judging, and through a store
// walk between evaluate and result load when it does: the controller then
// walks the pad sequence store, up to SEQ_DEPTH entries, one entry per cycle
// to check that it alternates. The result sits in an output register, so a
// new tick is taken while the last result still waits; a tick only waits at
// its result load if the last result has not yet been taken. The four settings
// (touch threshold, longest gesture time, debounce time and fewest entries)
// sit on a plain write port and should be changed only while the block is
// quiet. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_pad_swipe_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tpsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpsd_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tpsd_pkg::LEVEL_W-1:0]   req_raw_a_level,
   input  logic [tpsd_pkg::LEVEL_W-1:0]   req_raw_b_level,
   input  logic [tpsd_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_gesture_code,
   output logic                           rsp_pad_a_touched,
   output logic                           rsp_pad_b_touched
);
   import tpsd_pkg::*;

   // Commands from the controller and status back from the datapath.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller owns the handshakes and the sequencing of each word.
   tpsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the settings, the recording state, the sequence
   // store and the result register.
   tpsd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_raw_a_level   (req_raw_a_level),
      .req_raw_b_level   (req_raw_b_level),
      .req_now_ms        (req_now_ms),
      .cmd               (cmd),
      .status            (status),
      .rsp_gesture_code  (rsp_gesture_code),
      .rsp_pad_a_touched (rsp_pad_a_touched),
      .rsp_pad_b_touched (rsp_pad_b_touched)
   );

endmodule
